>>> hdl/first_fit_heap_allocator_defines.svh
// Assertion macros for the first-fit heap allocator checker.
// No dependencies; included by the checker file.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define FFHA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FFHA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

   localparam int unsigned MaxBlocksDefault = 64;
   localparam logic [31:0] HeapLimitReset   = 32'd65536;
   localparam logic [6:0]  HeaderReset      = 7'd24;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_RESIZE = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NULL       = 3'd1,
      ST_HEAP_FULL  = 3'd2,
      ST_TABLE_FULL = 3'd3,
      ST_BAD_ADDR   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_HEAP_BASE    = 2'd0,
      CSR_HEAP_LIMIT   = 2'd1,
      CSR_HEADER_BYTES = 2'd2,
      CSR_NONE         = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] size;
      logic        is_free;
   } entry_type;

   localparam int unsigned EntryWidth = $bits(entry_type);

endpackage

>>> hdl/ffha_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffha_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> hdl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: sequencer, registers, block table.
// Depends on ffha_pkg and ffha_ram.
//
// Channel | Direction | Payload                                      | Handshake
// req     | in        | operation, request_size, address             | req_valid/req_ready
// rsp     | out       | result_address, copy_bytes, status           | rsp_valid/rsp_ready
// csr     | in        | index, wdata                                 | csr_we, no wait
//
// One beat at a time: req_ready is high only while the sequencer is idle.
// A table walk (first-fit search or address lookup) reads one entry per cycle from
// the table RAM, pipelined over its registered read port.
// A free adds the neighbor reads and the merge, then a shift of the tail of the
// table, one entry per cycle.
// Synchronous reset clears the state, count, heap top and valid flags and loads the CSR defaults;
// the table needs no clear. A finished result holds in the rsp register until taken; the sequencer waits for it.
module first_fit_heap_allocator #(
   parameter int unsigned MAX_BLOCKS = ffha_pkg::MaxBlocksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_address,
   output logic [31:0] rsp_copy_bytes,
   output logic [2:0]  rsp_status,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned IW = $clog2(MAX_BLOCKS);
   localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_SCAN   = 8'b0000_0010,
      S_FREE_P = 8'b0000_0100,
      S_FREE_N = 8'b0000_1000,
      S_FREE_C = 8'b0001_0000,
      S_MERGE  = 8'b0010_0000,
      S_SHIFT  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [31:0] base_ff, limit_ff;
   logic [6:0]  hdr_ff;
   logic [31:0] hdr32;

   // heap bookkeeping
   logic [CW-1:0] count_ff, count_in;
   logic [32:0]   top_ff, top_in;

   // captured request
   logic [31:0] size_ff, size_in, addr_ff, addr_in, target_ff, target_in;

   // walk control
   logic          scan_fit_ff, scan_fit_in;   // 1: first-fit search, 0: address lookup
   logic          for_resize_ff, for_resize_in;
   logic          resize_ff, resize_in;       // relocating resize: free old block after alloc
   logic [CW-1:0] issue_ff, issue_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [CW-1:0] chk_idx_ff, chk_idx_in;
   logic [CW-1:0] cur_idx_ff, cur_idx_in, old_idx_ff, old_idx_in;
   logic [CW-1:0] base_idx_ff, base_idx_in, dst_ff, dst_in;
   logic [1:0]    k_ff, k_in;
   logic          nf_ff, nf_in;
   ffha_pkg::entry_type cur_ent_ff, cur_ent_in, old_ent_ff, old_ent_in;
   ffha_pkg::entry_type prev_ent_ff, prev_ent_in;
   logic [31:0]   acc_ff, acc_in, next_size_ff, next_size_in, merge_start_ff, merge_start_in;

   // pending and presented result
   logic [31:0] res_ff, res_in, copy_ff, copy_in;
   ffha_pkg::status_type st_ff, st_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_res_ff, rsp_res_in, rsp_copy_ff, rsp_copy_in;
   logic [2:0]  rsp_st_ff, rsp_st_in;

   // table RAM
   logic                ram_we;
   logic [IW-1:0]       ram_waddr, ram_raddr;
   ffha_pkg::entry_type ram_wdata, ram_rdata;

   logic        issue, hit, pf, nf, accept;
   logic [33:0] heap_end;

   ffha_ram #(
      .WIDTH(ffha_pkg::EntryWidth),
      .DEPTH(MAX_BLOCKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign hdr32    = 32'(hdr_ff);
   assign accept   = req_valid && req_ready;
   assign heap_end = {1'b0, top_ff} + 34'(hdr_ff) + 34'(size_ff);

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_res_ff;
   assign rsp_copy_bytes     = rsp_copy_ff;
   assign rsp_status         = rsp_st_ff;

   // Configuration registers: write on enable, ignore unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         limit_ff <= ffha_pkg::HeapLimitReset;
         hdr_ff   <= ffha_pkg::HeaderReset;
      end else if (csr_we) begin
         case (ffha_pkg::csr_idx_type'(csr_index))
            ffha_pkg::CSR_HEAP_BASE:    base_ff  <= csr_wdata;
            ffha_pkg::CSR_HEAP_LIMIT:   limit_ff <= csr_wdata;
            ffha_pkg::CSR_HEADER_BYTES: hdr_ff   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      top_in         = top_ff;
      size_in        = size_ff;
      addr_in        = addr_ff;
      target_in      = target_ff;
      scan_fit_in    = scan_fit_ff;
      for_resize_in  = for_resize_ff;
      resize_in      = resize_ff;
      issue_in       = issue_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = issue_ff;
      cur_idx_in     = cur_idx_ff;
      old_idx_in     = old_idx_ff;
      base_idx_in    = base_idx_ff;
      dst_in         = dst_ff;
      k_in           = k_ff;
      nf_in          = nf_ff;
      cur_ent_in     = cur_ent_ff;
      old_ent_in     = old_ent_ff;
      prev_ent_in    = prev_ent_ff;
      acc_in         = acc_ff;
      next_size_in   = next_size_ff;
      merge_start_in = merge_start_ff;
      res_in         = res_ff;
      copy_in        = copy_ff;
      st_in          = st_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_res_in     = rsp_res_ff;
      rsp_copy_in    = rsp_copy_ff;
      rsp_st_in      = rsp_st_ff;
      ram_we         = 1'b0;
      ram_waddr      = '0;
      ram_wdata      = '0;
      ram_raddr      = issue_ff[IW-1:0];
      issue          = 1'b0;
      hit            = 1'b0;
      pf             = 1'b0;
      nf             = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               size_in       = req_request_size;
               addr_in       = req_address;
               target_in     = req_address - base_ff - hdr32;
               res_in        = '0;
               copy_in       = '0;
               st_in         = ffha_pkg::ST_NULL;
               resize_in     = 1'b0;
               issue_in      = '0;
               for_resize_in = 1'b0;
               state_in      = S_DONE;
               case (ffha_pkg::op_type'(req_operation))
                  ffha_pkg::OP_ALLOC: begin
                     if (req_request_size != '0) begin
                        scan_fit_in = 1'b1;
                        state_in    = S_SCAN;
                     end
                  end
                  ffha_pkg::OP_FREE: begin
                     if (req_address != '0) begin
                        scan_fit_in = 1'b0;
                        state_in    = S_SCAN;
                     end
                  end
                  ffha_pkg::OP_RESIZE: begin
                     if (req_address == '0) begin
                        if (req_request_size != '0) begin
                           scan_fit_in = 1'b1;
                           state_in    = S_SCAN;
                        end
                     end else begin
                        scan_fit_in   = 1'b0;
                        for_resize_in = (req_request_size != '0);
                        state_in      = S_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_SCAN: begin
            // Issue one read per cycle and check the entry read the cycle before.
            issue      = (issue_ff < count_ff);
            chk_vld_in = issue;
            if (issue) begin
               issue_in = issue_ff + 1'b1;
            end
            if (scan_fit_ff) begin
               hit = chk_vld_ff && ram_rdata.is_free && (ram_rdata.size >= size_ff);
            end else begin
               hit = chk_vld_ff && !ram_rdata.is_free && (ram_rdata.start == target_ff);
            end

            if (hit && scan_fit_ff) begin
               // Take the first free block that fits, without a split.
               ram_we    = 1'b1;
               ram_waddr = chk_idx_ff[IW-1:0];
               ram_wdata = '{start: ram_rdata.start, size: ram_rdata.size, is_free: 1'b0};
               res_in    = base_ff + ram_rdata.start + hdr32;
               st_in     = ffha_pkg::ST_OK;
               state_in  = S_DONE;
               if (resize_ff) begin
                  copy_in    = old_ent_ff.size;
                  cur_idx_in = old_idx_ff;
                  cur_ent_in = old_ent_ff;
                  state_in   = S_FREE_P;
               end
            end else if (hit) begin
               if (for_resize_ff && (ram_rdata.size >= size_ff)) begin
                  res_in   = addr_ff;
                  st_in    = ffha_pkg::ST_OK;
                  state_in = S_DONE;
               end else if (for_resize_ff) begin
                  // Block too small: remember it, then search for a new one.
                  old_idx_in  = chk_idx_ff;
                  old_ent_in  = ram_rdata;
                  resize_in   = 1'b1;
                  scan_fit_in = 1'b1;
                  issue_in    = '0;
                  chk_vld_in  = 1'b0;
               end else begin
                  cur_idx_in = chk_idx_ff;
                  cur_ent_in = ram_rdata;
                  st_in      = ffha_pkg::ST_OK;
                  state_in   = S_FREE_P;
               end
            end else if (!issue && !chk_vld_ff) begin
               state_in = S_DONE;
               if (!scan_fit_ff) begin
                  st_in = ffha_pkg::ST_BAD_ADDR;
               end else if (heap_end > {2'b00, limit_ff}) begin
                  res_in = '0;
                  st_in  = ffha_pkg::ST_HEAP_FULL;
               end else if (count_ff == CW'(MAX_BLOCKS)) begin
                  res_in = '0;
                  st_in  = ffha_pkg::ST_TABLE_FULL;
               end else begin
                  // Append a block at the heap top.
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[IW-1:0];
                  ram_wdata = '{start: top_ff[31:0], size: size_ff, is_free: 1'b0};
                  count_in  = count_ff + 1'b1;
                  top_in    = heap_end[32:0];
                  res_in    = base_ff + top_ff[31:0] + hdr32;
                  st_in     = ffha_pkg::ST_OK;
                  if (resize_ff) begin
                     copy_in    = old_ent_ff.size;
                     cur_idx_in = old_idx_ff;
                     cur_ent_in = old_ent_ff;
                     state_in   = S_FREE_P;
                  end
               end
            end
         end

         S_FREE_P: begin
            ram_raddr = IW'(cur_idx_ff - 1'b1);
            state_in  = S_FREE_N;
         end

         S_FREE_N: begin
            prev_ent_in = ram_rdata;
            ram_raddr   = IW'(cur_idx_ff + 1'b1);
            state_in    = S_FREE_C;
         end

         S_FREE_C: begin
            // Decide which neighbors merge; fold the lower pair now.
            pf           = (cur_idx_ff != '0) && prev_ent_ff.is_free;
            nf           = ((cur_idx_ff + 1'b1) < count_ff) && ram_rdata.is_free;
            nf_in        = nf;
            next_size_in = ram_rdata.size;
            k_in         = {1'b0, pf} + {1'b0, nf};
            if (pf) begin
               base_idx_in    = cur_idx_ff - 1'b1;
               merge_start_in = prev_ent_ff.start;
               acc_in         = prev_ent_ff.size + hdr32 + cur_ent_ff.size;
            end else begin
               base_idx_in    = cur_idx_ff;
               merge_start_in = cur_ent_ff.start;
               acc_in         = cur_ent_ff.size;
            end
            state_in = S_MERGE;
         end

         S_MERGE: begin
            ram_we    = 1'b1;
            ram_waddr = base_idx_ff[IW-1:0];
            ram_wdata = '{start: merge_start_ff,
                          size: nf_ff ? (acc_ff + hdr32 + next_size_ff) : acc_ff,
                          is_free: 1'b1};
            dst_in    = base_idx_ff + 1'b1;
            issue_in  = base_idx_ff + 1'b1 + CW'(k_ff);
            state_in  = (k_ff == '0) ? S_DONE : S_SHIFT;
         end

         S_SHIFT: begin
            // Move the tail of the table down by k entries.
            issue      = (issue_ff < count_ff);
            chk_vld_in = issue;
            if (issue) begin
               issue_in = issue_ff + 1'b1;
            end
            if (chk_vld_ff) begin
               ram_we    = 1'b1;
               ram_waddr = dst_ff[IW-1:0];
               ram_wdata = ram_rdata;
               dst_in    = dst_ff + 1'b1;
            end
            if (!issue && !chk_vld_ff) begin
               count_in = count_ff - CW'(k_ff);
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_copy_in  = copy_ff;
               rsp_st_in    = st_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         top_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         resize_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         resize_ff    <= resize_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff        <= size_in;
      addr_ff        <= addr_in;
      target_ff      <= target_in;
      scan_fit_ff    <= scan_fit_in;
      for_resize_ff  <= for_resize_in;
      issue_ff       <= issue_in;
      chk_idx_ff     <= chk_idx_in;
      cur_idx_ff     <= cur_idx_in;
      old_idx_ff     <= old_idx_in;
      base_idx_ff    <= base_idx_in;
      dst_ff         <= dst_in;
      k_ff           <= k_in;
      nf_ff          <= nf_in;
      cur_ent_ff     <= cur_ent_in;
      old_ent_ff     <= old_ent_in;
      prev_ent_ff    <= prev_ent_in;
      acc_ff         <= acc_in;
      next_size_ff   <= next_size_in;
      merge_start_ff <= merge_start_in;
      res_ff         <= res_in;
      copy_ff        <= copy_in;
      st_ff          <= st_in;
      rsp_res_ff     <= rsp_res_in;
      rsp_copy_ff    <= rsp_copy_in;
      rsp_st_ff      <= rsp_st_in;
   end

endmodule

>>> hdl/ffha_checker.sv
// Port-level checker for the first-fit heap allocator, bound to the top level.
// Depends on first_fit_heap_allocator_defines.svh, ffha_pkg and first_fit_heap_allocator.
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result_address,
   input logic [31:0] rsp_copy_bytes,
   input logic [2:0]  rsp_status
);

   `FFHA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_address) && $stable(rsp_status), "rsp beat dropped or changed while stalled")
   `FFHA_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "req accepted while previous beat still in work")
   `FFHA_ASSERT_IMP(a_err_no_addr, clock, reset, rsp_valid && (rsp_status != ffha_pkg::ST_OK), rsp_result_address == 32'd0, "failed request returned an address")
   `FFHA_ASSERT_IMP(a_copy_ok, clock, reset, rsp_valid && (rsp_copy_bytes != 32'd0), rsp_status == ffha_pkg::ST_OK, "copy bytes on a failed request")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

>>> sim/first_fit_heap_allocator_checker.sv
// Checker for the first-fit heap allocator: watches req/rsp beats, predicts results.
// Depends on ffha_pkg; instantiated by first_fit_heap_allocator_test.
module first_fit_heap_allocator_checker #(
   parameter int unsigned MAX_BLOCKS = ffha_pkg::MaxBlocksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_address,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_result_address,
   input  logic [31:0] rsp_copy_bytes,
   input  logic [2:0]  rsp_status,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          grant_count,
   output int          live_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ffha_pkg::*;

   typedef struct {
      logic [31:0] addr;
      logic [31:0] copy;
      status_type  st;
   } grant_type;

   grant_type   grant_q[$];
   logic [31:0] base_r, limit_r;
   logic [6:0]  hdr_r;
   logic [31:0] blk_start[MAX_BLOCKS];
   logic [31:0] blk_size[MAX_BLOCKS];
   logic        blk_free[MAX_BLOCKS];
   int unsigned blk_count;
   logic [32:0] top_r;

   assign pending = grant_q.size();

   function automatic logic [31:0] user_of(int unsigned i);
      return base_r + blk_start[i] + 32'(hdr_r);
   endfunction

   function automatic int unsigned lookup_used(logic [31:0] a);
      for (int unsigned i = 0; i < blk_count; i++)
         if (!blk_free[i] && user_of(i) == a) return i;
      return MAX_BLOCKS;
   endfunction

   function automatic status_type grant(logic [31:0] sz, output logic [31:0] ua);
      logic [33:0] fin;
      ua = '0;
      if (sz == 0) return ST_NULL;
      for (int unsigned i = 0; i < blk_count; i++)
         if (blk_free[i] && blk_size[i] >= sz) begin
            blk_free[i] = 1'b0;
            ua = user_of(i);
            return ST_OK;
         end
      fin = 34'(top_r) + 34'(hdr_r) + 34'(sz);
      if (fin > 34'(limit_r)) return ST_HEAP_FULL;
      if (blk_count >= MAX_BLOCKS) return ST_TABLE_FULL;
      blk_start[blk_count] = top_r[31:0];
      blk_size[blk_count]  = sz;
      blk_free[blk_count]  = 1'b0;
      ua = user_of(blk_count);
      blk_count++;
      top_r = fin[32:0];
      return ST_OK;
   endfunction

   function automatic status_type release_blk(logic [31:0] a);
      int unsigned k, j;
      if (a == 0) return ST_NULL;
      k = lookup_used(a);
      if (k >= MAX_BLOCKS) return ST_BAD_ADDR;
      blk_free[k] = 1'b1;
      k = 0;
      while (k + 1 < blk_count) begin
         if (blk_free[k] && blk_free[k+1]) begin
            blk_size[k] = blk_size[k] + 32'(hdr_r) + blk_size[k+1];
            for (j = k + 1; j + 1 < blk_count; j++) begin
               blk_start[j] = blk_start[j+1];
               blk_size[j]  = blk_size[j+1];
               blk_free[j]  = blk_free[j+1];
            end
            blk_count--;
         end else k++;
      end
      return ST_OK;
   endfunction

   function automatic grant_type heap_step(logic [1:0] op, logic [31:0] sz,
                                           logic [31:0] a);
      grant_type g;
      int unsigned k;
      logic [31:0] old_sz;
      g.addr = '0; g.copy = '0; g.st = ST_NULL;
      case (op_type'(op))
         OP_ALLOC: g.st = grant(sz, g.addr);
         OP_FREE:  g.st = release_blk(a);
         OP_RESIZE: begin
            if (a == 0) g.st = grant(sz, g.addr);
            else if (sz == 0) g.st = release_blk(a);
            else begin
               k = lookup_used(a);
               if (k >= MAX_BLOCKS) g.st = ST_BAD_ADDR;
               else if (blk_size[k] >= sz) begin
                  g.addr = a; g.st = ST_OK;
               end else begin
                  old_sz = blk_size[k];
                  g.st = grant(sz, g.addr);
                  if (g.st == ST_OK) begin
                     g.copy = (old_sz < sz) ? old_sz : sz;
                     void'(release_blk(a));
                  end else g.addr = '0;
               end
            end
         end
         default: ;
      endcase
      return g;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      grant_type g;
      int n;
      if (reset) begin
         base_r = '0; limit_r = HeapLimitReset; hdr_r = HeaderReset;
         blk_count = 0; top_r = '0; grant_q.delete();
         grant_count = 0; live_count = 0; fail_count = 0;
      end else begin
         if (csr_we)
            case (csr_idx_type'(csr_index))
               CSR_HEAP_BASE:    base_r  = csr_wdata;
               CSR_HEAP_LIMIT:   limit_r = csr_wdata;
               CSR_HEADER_BYTES: hdr_r   = csr_wdata[6:0];
               default: ;
            endcase
         if (rsp_valid && rsp_ready) begin
            if (grant_q.size() == 0) begin
               $display("unexpected result beat at %0t", $realtime);
               fail_count++;
            end else begin
               g = grant_q.pop_front();
               if (rsp_result_address !== g.addr) report("address", rsp_result_address, g.addr);
               if (rsp_copy_bytes !== g.copy) report("copy", rsp_copy_bytes, g.copy);
               if (rsp_status !== g.st) report("status", 32'(rsp_status), 32'(g.st));
            end
         end
         if (req_valid && req_ready) begin
            g = heap_step(req_operation, req_request_size, req_address);
            grant_q = {grant_q, g};
            if (g.st == ST_OK && g.addr != 0) grant_count++;
         end
         n = 0;
         for (int unsigned i = 0; i < blk_count; i++) if (!blk_free[i]) n++;
         live_count = n;
      end
   end
endmodule

>>> sim/first_fit_heap_allocator_test.sv
// Testbench top for the first-fit heap allocator: clock, reset, stimulus, verdict.
// Depends on ffha_pkg, first_fit_heap_allocator and first_fit_heap_allocator_checker.
module first_fit_heap_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ffha_pkg::*;

   localparam int MaxCycles = 2_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic [31:0] req_request_size = '0;
   logic [31:0] req_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result_address, rsp_copy_bytes;
   logic [2:0]  rsp_status;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int          fail_count, pending, grant_count, live_count;
   int          cycle_count = 0;
   int          beats_sent = 0;
   bit          calm = 1'b0;    // no idling in the last part of the run

   // Addresses handed out and believed live; feed free and resize.
   logic [31:0] held_addrs[$];
   logic [31:0] cur_base = '0;
   logic [6:0]  cur_hdr = HeaderReset;

   always #5 clock = ~clock;

   first_fit_heap_allocator dut (.*);

   first_fit_heap_allocator_checker chk (.*);

   // Watchdog: bound the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MaxCycles) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Track granted addresses from the result channel.
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready && rsp_status == ST_OK && rsp_result_address != 0
          && held_addrs.size() < 200)
         held_addrs = {held_addrs, rsp_result_address};

   // Receiver: stall in random bursts, with quiet stretches.
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
            rsp_ready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   // Send one beat; hold it until accepted, optionally idle first.
   task automatic send_beat(op_type op, logic [31:0] sz, logic [31:0] a);
      @(negedge clock);
      if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 17)) @(negedge clock);
      req_valid <= 1'b1;
      req_operation <= op;
      req_request_size <= sz;
      req_address <= a;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid <= 1'b0;
      beats_sent++;
   endtask

   // Wait until every expected result is back, then let the sequencer settle.
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (250) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HEAP_BASE) cur_base = val;
      if (idx == CSR_HEADER_BYTES) cur_hdr = val[6:0];
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_held(bit drop);
      int k;
      logic [31:0] a;
      if (held_addrs.size() == 0) return 32'h0;
      k = $urandom_range(0, held_addrs.size() - 1);
      a = held_addrs[k];
      if (drop) held_addrs.delete(k);
      return a;
   endfunction

   function automatic logic [31:0] rand_size(int unsigned mx);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'($urandom_range(0, 3));
         default: return 32'($urandom_range(1, mx));
      endcase
   endfunction

   // One random beat: mostly well-formed alloc/free/resize of live blocks.
   task automatic random_beat(int unsigned mx);
      int r;
      logic [31:0] a;
      r = $urandom_range(0, 99);
      if (r < 40) send_beat(OP_ALLOC, rand_size(mx), $urandom);
      else if (r < 65) begin
         a = pick_held(1'b1);
         send_beat(OP_FREE, $urandom, a);
      end else if (r < 85) begin
         a = pick_held(1'b1);
         send_beat(OP_RESIZE, rand_size(mx), a);
      end else if (r < 92) begin
         // noise address, or double free of a stale one
         a = $urandom_range(0, 1) ? $urandom : cur_base + 32'(cur_hdr);
         send_beat(op_type'($urandom_range(1, 2)), rand_size(mx), a);
      end else if (r < 96) send_beat(OP_RESIZE, rand_size(mx), 32'h0);
      else send_beat(OP_UNUSED, $urandom, $urandom);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset settings, every operation and the named corner cases.
      send_beat(OP_ALLOC, 32'h0, 32'h0);               // zero-size allocate
      send_beat(OP_ALLOC, 32'd100, 32'h0);
      send_beat(OP_ALLOC, 32'd40, 32'h0);
      send_beat(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // heap full
      send_beat(OP_FREE, 32'h0, 32'h0);                // null free
      send_beat(OP_FREE, 32'h0, 32'd24);               // free first block
      send_beat(OP_FREE, 32'h0, 32'd24);               // already free
      send_beat(OP_ALLOC, 32'd50, 32'h0);              // first-fit reuse, no split
      send_beat(OP_RESIZE, 32'd10, 32'd24);            // fits, same address
      send_beat(OP_RESIZE, 32'd500, 32'd24);           // relocate with copy
      send_beat(OP_RESIZE, 32'd8, 32'h0);              // resize of null
      send_beat(OP_RESIZE, 32'hFFFF_0000, 32'd148);    // relocation fails
      send_beat(OP_RESIZE, 32'h0, 32'd148);            // resize to zero frees
      send_beat(OP_RESIZE, 32'd4, 32'h1234_5678);      // bad address
      send_beat(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(OP_FREE, 32'h0, 32'hFFFF_FFFF);
      drain();

      // Hold off: extremes of the registers, fill the table to its limit.
      write_reg(CSR_HEAP_BASE, 32'hFFFF_FFF0);         // user addresses wrap
      write_reg(CSR_HEADER_BYTES, 32'd1);
      write_reg(CSR_HEAP_LIMIT, 32'hFFFF_FFFF);
      write_reg(csr_idx_type'(CSR_NONE), 32'hDEAD_BEEF); // ignored index
      held_addrs.delete();
      repeat (70) send_beat(OP_ALLOC, 32'd1, 32'h0);    // last ones: table full
      send_beat(OP_FREE, 32'h0, 32'hFFFF_FFF0 + 32'd1 + 32'd2);
      drain();

      // Phases with varied settings and random traffic.
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: begin write_reg(CSR_HEAP_BASE, 32'h0); write_reg(CSR_HEADER_BYTES, 32'd64);
                     write_reg(CSR_HEAP_LIMIT, 32'h0); end
            1: begin write_reg(CSR_HEAP_LIMIT, 32'd4096); write_reg(CSR_HEADER_BYTES, 32'd0); end
            2: begin write_reg(CSR_HEADER_BYTES, 32'd127); write_reg(CSR_HEAP_BASE, $urandom); end
            3: begin write_reg(CSR_HEAP_LIMIT, 32'hFFFF_FFFF); write_reg(CSR_HEADER_BYTES, 32'd8);
                     write_reg(CSR_HEAP_BASE, 32'h8000_0000); end
            4: begin write_reg(CSR_HEAP_LIMIT, 32'd65536); write_reg(CSR_HEADER_BYTES, 32'd24);
                     write_reg(CSR_HEAP_BASE, 32'h0001_0000); end
            default: write_reg(CSR_HEAP_BASE, $urandom);
         endcase
         held_addrs.delete();
         if (ph == 5) calm = 1'b1;
         repeat (228) random_beat(ph == 3 ? 32'hFFFF : 300);
      end
      drain();

      $display("covered %0d beats over 8 register settings; %0d grants, %0d blocks left live",
               beats_sent, grant_count, live_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

>>> sim.f
+incdir+hdl
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/first_fit_heap_allocator.sv
hdl/ffha_checker.sv
sim/first_fit_heap_allocator_checker.sv
sim/first_fit_heap_allocator_test.sv
